/* src/think_tag_stripper_macros.svh */
// Assertion macros for the think tag stripper.
`ifndef THINK_TAG_STRIPPER_MACROS_SVH
`define THINK_TAG_STRIPPER_MACROS_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TTS_ASSERT(lbl, clk, rstn, prop, msg)
`define TTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* src/tts_pkg.sv */
// Shared constants, types and character helpers of the think tag stripper.
package tts_pkg;

  localparam int unsigned HOLD_DEPTH  = 32;
  localparam int unsigned LENGTH_BITS = 24;
  localparam int unsigned HOLD_PTR_W  = $clog2(HOLD_DEPTH);
  localparam int unsigned HOLD_CNT_W  = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned KEPT_W      = 24;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    WS_SPACE,
    WS_TAB,
    WS_LF,
    WS_CR
  } ws_code_e;

  typedef struct packed {
    logic       en;
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
    logic       ovf;
  } put_t;

  typedef struct packed {
    logic     push;
    logic     pop;
    logic     rd;
    logic     clear;
    ws_code_e code;
  } hold_req_t;

  typedef struct packed {
    logic     empty;
    logic     full;
    ws_code_e code;
  } hold_sts_t;

  // "<think>", lower case letters
  function automatic logic [7:0] open_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_LT;
      3'd1:    ch = 8'h74;
      3'd2:    ch = 8'h68;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h6E;
      3'd5:    ch = 8'h6B;
      default: ch = CH_GT;
    endcase
    return ch;
  endfunction

  // "</think>"
  function automatic logic [7:0] close_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_LT;
      3'd1:    ch = CH_SLASH;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h68;
      3'd4:    ch = 8'h69;
      3'd5:    ch = 8'h6E;
      3'd6:    ch = 8'h6B;
      default: ch = CH_GT;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic ws_code_e ws_encode(input logic [7:0] c);
    ws_code_e code;
    case (c)
      CH_TAB:  code = WS_TAB;
      CH_LF:   code = WS_LF;
      CH_CR:   code = WS_CR;
      default: code = WS_SPACE;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] ws_decode(input ws_code_e code);
    logic [7:0] ch;
    case (code)
      WS_TAB:  ch = CH_TAB;
      WS_LF:   ch = CH_LF;
      WS_CR:   ch = CH_CR;
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  function automatic logic [HOLD_PTR_W-1:0] hold_ptr_next(input logic [HOLD_PTR_W-1:0] ptr);
    logic [HOLD_PTR_W-1:0] nxt;
    if (ptr == HOLD_PTR_W'(HOLD_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + HOLD_PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage

/* src/tts_ifs.sv */
// Input and result channel interfaces of the think tag stripper.
interface tts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_valid;
  logic       end_of_text;

  modport source (output valid, output text_byte, output byte_valid, output end_of_text,
                  input ready);
  modport sink (input valid, input text_byte, input byte_valid, input end_of_text,
                output ready);
endinterface

interface tts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        run_last;
  logic [23:0] kept_length;
  logic        hold_overflow;

  modport source (output valid, output out_byte, output out_valid, output run_last,
                  output kept_length, output hold_overflow, input ready);
  modport sink (input valid, input out_byte, input out_valid, input run_last,
                input kept_length, input hold_overflow, output ready);
endinterface

/* src/tts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tts_hold.sv */
// Trailing whitespace hold queue: ring pointers around the hold RAM.
`include "think_tag_stripper_macros.svh"

module tts_hold (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tts_pkg::hold_req_t req_i,
  output tts_pkg::hold_sts_t sts_o
);

  logic [tts_pkg::HOLD_PTR_W-1:0] head_q, head_d;
  logic [tts_pkg::HOLD_PTR_W-1:0] tail_q, tail_d;
  logic [tts_pkg::HOLD_CNT_W-1:0] count_q, count_d;
  logic [1:0]                     rdata;
  logic                           full;
  logic                           empty;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (req_i.push) begin
      tail_d  = tts_pkg::hold_ptr_next(tail_q);
      count_d = count_q + tts_pkg::HOLD_CNT_W'(1);
    end else if (req_i.pop) begin
      head_d  = tts_pkg::hold_ptr_next(head_q);
      count_d = count_q - tts_pkg::HOLD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  tts_ram #(
    .Width (2),
    .Depth (tts_pkg::HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.push),
    .waddr_i (tail_q),
    .wdata_i (2'(req_i.code)),
    .re_i    (req_i.rd),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign empty = (count_q == '0);
  assign full  = (count_q == tts_pkg::HOLD_CNT_W'(tts_pkg::HOLD_DEPTH));

  assign sts_o.empty = empty;
  assign sts_o.full  = full;
  assign sts_o.code  = tts_pkg::ws_code_e'(rdata);

  `TTS_ASSERT(a_push_not_full, clk_i, rst_ni, req_i.push |-> !full, "push into full hold queue")
  `TTS_ASSERT(a_pop_not_empty, clk_i, rst_ni, req_i.pop |-> !empty, "pop from empty hold queue")
  `TTS_ASSERT(a_rd_not_empty, clk_i, rst_ni, req_i.rd |-> !empty, "read of empty hold queue")

endmodule

/* src/tts_scan.sv */
// Tag matcher and result sequencer: scans bytes, releases tags, drives the hold queue.
`include "think_tag_stripper_macros.svh"

module tts_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  tts_in_if.sink             text_i,
  input  logic               can_put_i,
  output tts_pkg::put_t      put_o,
  output tts_pkg::hold_req_t hold_req_o,
  input  tts_pkg::hold_sts_t hold_sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT,
    S_FLUSH,
    S_OVF,
    S_PUT,
    S_END
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] match_q, match_d;
  logic       inside_q, inside_d;
  logic       seen_q, seen_d;
  logic       fresh_q, fresh_d;
  logic       end_q, end_d;
  logic [3:0] rel_n_q, rel_n_d;
  logic [3:0] rel_cnt_q, rel_cnt_d;
  logic [7:0] c_q, c_d;
  logic [7:0] e_q, e_d;
  logic [7:0] buf_q [8];

  logic       buf_we;
  logic [2:0] buf_wa;
  logic [7:0] buf_wd;
  logic [7:0] c_in;
  logic [7:0] c_fold;
  logic [2:0] pp;
  logic       hit;
  logic       fail;
  logic       go_emit;
  logic       work_left;

  assign work_left = (rel_cnt_q != rel_n_q) || fresh_q || end_q;
  assign c_in      = text_i.text_byte;
  assign c_fold    = text_i.text_byte | tts_pkg::CASE_BIT;
  assign pp        = match_q[2:0];

  always_comb begin
    state_d   = state_q;
    match_d   = match_q;
    inside_d  = inside_q;
    seen_d    = seen_q;
    fresh_d   = fresh_q;
    end_d     = end_q;
    rel_n_d   = rel_n_q;
    rel_cnt_d = rel_cnt_q;
    c_d       = c_q;
    e_d       = e_q;
    buf_we    = 1'b0;
    buf_wa    = pp;
    buf_wd    = c_in;
    hit       = 1'b0;
    fail      = 1'b0;
    go_emit   = 1'b0;
    put_o     = '0;
    hold_req_o      = '0;
    hold_req_o.code = tts_pkg::ws_encode(e_q);
    text_i.ready    = 1'b0;

    case (state_q)
      S_IDLE: begin
        text_i.ready = 1'b1;
        if (text_i.valid) begin
          c_d   = c_in;
          end_d = text_i.end_of_text;
          if (text_i.byte_valid && inside_q) begin
            if (pp inside {[3'd2:3'd6]}) begin
              hit = (c_fold == tts_pkg::close_char(pp));
            end else begin
              hit = (c_in == tts_pkg::close_char(pp));
            end
            if (hit && pp == 3'd7) begin
              inside_d = 1'b0;
              match_d  = '0;
            end else if (hit) begin
              match_d = match_q + 4'd1;
            end else if (c_in == tts_pkg::CH_LT) begin
              match_d = 4'd1;
            end else begin
              match_d = '0;
            end
          end else if (text_i.byte_valid) begin
            if (match_q == 4'd0) begin
              if (c_in == tts_pkg::CH_LT) begin
                buf_we  = 1'b1;
                match_d = 4'd1;
              end else begin
                e_d     = c_in;
                go_emit = 1'b1;
              end
            end else if (match_q <= 4'd5) begin
              if (c_fold == tts_pkg::open_char(pp)) begin
                buf_we  = 1'b1;
                match_d = match_q + 4'd1;
              end else begin
                fail = 1'b1;
              end
            end else if (match_q == 4'd6) begin
              if (c_in == tts_pkg::CH_GT) begin
                match_d  = '0;
                inside_d = 1'b1;
              end else if (c_in == tts_pkg::CH_SLASH || c_in == tts_pkg::CH_SPACE) begin
                buf_we  = 1'b1;
                match_d = 4'd7;
              end else begin
                fail = 1'b1;
              end
            end else if (match_q == 4'd7) begin
              if (buf_q[6] == tts_pkg::CH_SLASH && c_in == tts_pkg::CH_GT) begin
                match_d = '0;
              end else if (buf_q[6] == tts_pkg::CH_SPACE && c_in == tts_pkg::CH_SLASH) begin
                buf_we  = 1'b1;
                match_d = 4'd8;
              end else begin
                fail = 1'b1;
              end
            end else begin
              if (c_in == tts_pkg::CH_GT) begin
                match_d = '0;
              end else begin
                fail = 1'b1;
              end
            end
            // failed partial tag: release held text, then rescan this byte
            if (fail) begin
              rel_n_d   = match_q;
              rel_cnt_d = '0;
              match_d   = '0;
              fresh_d   = 1'b1;
            end
          end
          if (fail || (text_i.end_of_text && !go_emit)) begin
            state_d = S_DISPATCH;
          end else if (go_emit) begin
            state_d = S_EMIT;
          end
        end
      end

      S_DISPATCH: begin
        if (rel_cnt_q != rel_n_q) begin
          e_d       = buf_q[rel_cnt_q[2:0]];
          rel_cnt_d = rel_cnt_q + 4'd1;
          state_d   = S_EMIT;
        end else if (fresh_q) begin
          fresh_d = 1'b0;
          if (c_q == tts_pkg::CH_LT) begin
            buf_we  = 1'b1;
            buf_wa  = '0;
            buf_wd  = c_q;
            match_d = 4'd1;
          end else begin
            e_d     = c_q;
            state_d = S_EMIT;
          end
        end else if (end_q) begin
          if (!inside_q && match_q != 4'd0) begin
            rel_n_d   = match_q;
            rel_cnt_d = '0;
            match_d   = '0;
          end else begin
            state_d = S_END;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        if (tts_pkg::is_ws(e_q)) begin
          if (!seen_q) begin
            state_d = work_left ? S_DISPATCH : S_IDLE;
          end else if (hold_sts_i.full) begin
            hold_req_o.rd = 1'b1;
            state_d       = S_OVF;
          end else begin
            hold_req_o.push = 1'b1;
            state_d         = work_left ? S_DISPATCH : S_IDLE;
          end
        end else begin
          seen_d = 1'b1;
          if (!hold_sts_i.empty) begin
            hold_req_o.rd = 1'b1;
            state_d       = S_FLUSH;
          end else begin
            state_d = S_PUT;
          end
        end
      end

      S_FLUSH, S_OVF: begin
        if (can_put_i) begin
          put_o.en       = 1'b1;
          put_o.ch       = tts_pkg::ws_decode(hold_sts_i.code);
          put_o.ch_valid = 1'b1;
          put_o.ovf      = (state_q == S_OVF);
          hold_req_o.pop = 1'b1;
          state_d        = S_EMIT;
        end
      end

      S_PUT: begin
        if (can_put_i) begin
          put_o.en       = 1'b1;
          put_o.ch       = e_q;
          put_o.ch_valid = 1'b1;
          state_d        = work_left ? S_DISPATCH : S_IDLE;
        end
      end

      S_END: begin
        if (can_put_i) begin
          put_o.en         = 1'b1;
          put_o.last       = 1'b1;
          hold_req_o.clear = 1'b1;
          match_d   = '0;
          inside_d  = 1'b0;
          seen_d    = 1'b0;
          fresh_d   = 1'b0;
          end_d     = 1'b0;
          rel_n_d   = '0;
          rel_cnt_d = '0;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      match_q   <= '0;
      inside_q  <= 1'b0;
      seen_q    <= 1'b0;
      fresh_q   <= 1'b0;
      end_q     <= 1'b0;
      rel_n_q   <= '0;
      rel_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      match_q   <= match_d;
      inside_q  <= inside_d;
      seen_q    <= seen_d;
      fresh_q   <= fresh_d;
      end_q     <= end_d;
      rel_n_q   <= rel_n_d;
      rel_cnt_q <= rel_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    e_q <= e_d;
    if (buf_we) begin
      buf_q[buf_wa] <= buf_wd;
    end
  end

  `TTS_ASSERT(a_put_has_slot, clk_i, rst_ni, put_o.en |-> can_put_i, "result put while output slot busy")
  `TTS_ASSERT_NEXT(a_end_resets, clk_i, rst_ni, put_o.en && put_o.last, match_q == 4'd0 && !inside_q && !seen_q && state_q == S_IDLE, "state not cleared after end of text")

endmodule

/* src/think_tag_stripper.sv */
// Top level of the think tag stripper: scanner, hold queue, result register and length count.
// An item is taken only while the sequencer is idle; a plain character passes the emit and
// put states into the result register before the next item is taken. Dropped tag bytes
// leave the sequencer idle, whitespace passes the emit state, and the end item passes the
// dispatch and end states after any released tag text. Held whitespace is released through
// the flush and emit states. Async active-low reset clears control state, not the hold RAM.
`include "think_tag_stripper_macros.svh"

module think_tag_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  tts_in_if.sink     text_i,
  tts_out_if.source  result_o
);

  tts_pkg::put_t      put;
  tts_pkg::hold_req_t hold_req;
  tts_pkg::hold_sts_t hold_sts;
  logic               can_put;

  logic                            ovld_q;
  logic [7:0]                      byte_q;
  logic                            chv_q;
  logic                            last_q;
  logic                            ovf_q;
  logic [tts_pkg::KEPT_W-1:0]      kept_q;
  logic [tts_pkg::LENGTH_BITS-1:0] len_q, len_d, len_next;

  assign can_put = !ovld_q || result_o.ready;

  tts_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_i     (text_i),
    .can_put_i  (can_put),
    .put_o      (put),
    .hold_req_o (hold_req),
    .hold_sts_i (hold_sts)
  );

  tts_hold u_hold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hold_req),
    .sts_o  (hold_sts)
  );

  always_comb begin
    len_next = len_q;
    if (put.ch_valid && len_q != '1) begin
      len_next = len_q + tts_pkg::LENGTH_BITS'(1);
    end
    len_d = len_q;
    if (put.en) begin
      len_d = put.last ? '0 : len_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      len_q  <= '0;
    end else begin
      len_q <= len_d;
      if (put.en) begin
        ovld_q <= 1'b1;
      end else if (result_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (put.en) begin
      byte_q <= put.ch;
      chv_q  <= put.ch_valid;
      last_q <= put.last;
      ovf_q  <= put.ovf;
      kept_q <= tts_pkg::KEPT_W'(len_next);
    end
  end

  assign result_o.valid         = ovld_q;
  assign result_o.out_byte      = byte_q;
  assign result_o.out_valid     = chv_q;
  assign result_o.run_last      = last_q;
  assign result_o.kept_length   = kept_q;
  assign result_o.hold_overflow = ovf_q;

  `TTS_ASSERT(a_ovf_is_char, clk_i, rst_ni, put.en && put.ovf |-> put.ch_valid && !put.last, "overflow flag on a non-character item")

endmodule

/* sim/tb.sv */
// Testbench for the think tag stripper: directed and random texts checked against a built-in predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] ch;
    logic       has_char;
    logic       eot;
    logic       pause;
  } text_item_t;

  typedef struct {
    logic [7:0]                 ch;
    logic                       is_char;
    logic                       last;
    logic [tts_pkg::KEPT_W-1:0] kept;
    logic                       ovf;
  } strip_result_t;

  typedef enum int {
    FRAG_BYTES, FRAG_WORD, FRAG_BLANKS, FRAG_OPEN, FRAG_CLOSE, FRAG_SELF,
    FRAG_PREFIX, FRAG_BROKEN, FRAG_NOOP
  } frag_e;

  typedef enum int {RX_STEADY, RX_JITTER, RX_BURSTY} rx_mode_e;

  localparam logic [7:0] OPEN_SEQ [6]  = '{tts_pkg::CH_LT, "t", "h", "i", "n", "k"};
  localparam logic [7:0] CLOSE_SEQ [8] = '{tts_pkg::CH_LT, tts_pkg::CH_SLASH, "t", "h", "i",
                                           "n", "k", tts_pkg::CH_GT};
  localparam logic [7:0] BLANKS [4]    = '{tts_pkg::CH_SPACE, tts_pkg::CH_TAB, tts_pkg::CH_LF,
                                           tts_pkg::CH_CR};
  localparam longint unsigned KEPT_MAX = (64'd1 << tts_pkg::LENGTH_BITS) - 1;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned STIM_ITEMS   = 285;

  logic clk = 1'b0;
  logic rst_n;

  tts_in_if  text_ch ();
  tts_out_if res_ch ();

  think_tag_stripper u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .text_i  (text_ch),
    .result_o(res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]      tag_chars [8];
  int unsigned     tag_len;
  bit              in_think;
  bit              text_started;
  logic [7:0]      held_blanks [$];
  longint unsigned kept_total;

  strip_result_t expected_q [$];
  text_item_t    text_items [$];
  int unsigned   mismatches;
  int unsigned   stim_count;
  bit            pause_next;

  function automatic bit is_blank(logic [7:0] c);
    return (c == tts_pkg::CH_SPACE) || (c == tts_pkg::CH_TAB) || (c == tts_pkg::CH_LF) ||
           (c == tts_pkg::CH_CR);
  endfunction

  function automatic bit char_match(logic [7:0] c, logic [7:0] want, bit fold);
    return fold ? ((c | tts_pkg::CASE_BIT) == want) : (c == want);
  endfunction

  function automatic void clear_stripper();
    tag_len      = 0;
    in_think     = 1'b0;
    text_started = 1'b0;
    held_blanks.delete();
    kept_total   = 0;
  endfunction

  function automatic void emit_result(logic [7:0] ch, bit is_char, bit last, bit ovf);
    strip_result_t r;
    if (is_char && kept_total < KEPT_MAX) begin
      kept_total++;
    end
    r.ch      = ch;
    r.is_char = is_char;
    r.last    = last;
    r.kept    = kept_total[tts_pkg::KEPT_W-1:0];
    r.ovf     = ovf;
    expected_q.push_back(r);
  endfunction

  // trailing blanks wait for a later kept char; leading ones vanish
  function automatic void keep_char(logic [7:0] c);
    if (is_blank(c)) begin
      if (!text_started) begin
        return;
      end
      if (held_blanks.size() >= tts_pkg::HOLD_DEPTH) begin
        emit_result(held_blanks.pop_front(), 1'b1, 1'b0, 1'b1);
      end
      held_blanks.push_back(c);
    end else begin
      text_started = 1'b1;
      while (held_blanks.size() != 0) begin
        emit_result(held_blanks.pop_front(), 1'b1, 1'b0, 1'b0);
      end
      emit_result(c, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  function automatic void flush_tag();
    int unsigned n;
    n = (tag_len > 8) ? 8 : tag_len;
    tag_len = 0;
    for (int i = 0; i < n; i++) begin
      keep_char(tag_chars[i]);
    end
  endfunction

  function automatic void start_scan(logic [7:0] c);
    if (c == tts_pkg::CH_LT) begin
      tag_chars[0] = c;
      tag_len = 1;
    end else begin
      keep_char(c);
    end
  endfunction

  function automatic void scan_block(logic [7:0] c);
    int unsigned p;
    p = tag_len & 7;
    if (char_match(c, CLOSE_SEQ[p], (p >= 2) && (p <= 6))) begin
      p++;
      if (p == 8) begin
        in_think = 1'b0;
        p = 0;
      end
    end else begin
      p = (c == tts_pkg::CH_LT) ? 1 : 0;
    end
    tag_len = p;
  endfunction

  function automatic void scan_text(logic [7:0] c);
    int unsigned p;
    bit grow;
    p = tag_len;
    grow = 1'b0;
    if (p == 0) begin
      start_scan(c);
      return;
    end
    if (p <= 5) begin
      grow = char_match(c, OPEN_SEQ[p], 1'b1);
    end else if (p == 6) begin
      if (c == tts_pkg::CH_GT) begin
        tag_len = 0;
        in_think = 1'b1;
        return;
      end
      grow = (c == tts_pkg::CH_SLASH) || (c == tts_pkg::CH_SPACE);
    end else if (p == 7) begin
      if (tag_chars[6] == tts_pkg::CH_SLASH && c == tts_pkg::CH_GT) begin
        tag_len = 0;
        return;
      end
      grow = (tag_chars[6] == tts_pkg::CH_SPACE) && (c == tts_pkg::CH_SLASH);
    end else if (c == tts_pkg::CH_GT) begin
      tag_len = 0;
      return;
    end
    if (grow && p < 8) begin
      tag_chars[p] = c;
      tag_len = p + 1;
      return;
    end
    flush_tag();
    start_scan(c);
  endfunction

  function automatic void predict_item(text_item_t it);
    if (it.has_char) begin
      if (in_think) begin
        scan_block(it.ch);
      end else begin
        scan_text(it.ch);
      end
    end
    if (it.eot) begin
      if (!in_think) begin
        flush_tag();
      end
      emit_result(8'h00, 1'b0, 1'b1, 1'b0);
      clear_stripper();
    end
  endfunction

  // stimulus building
  function automatic void add_item(logic [7:0] ch, bit has_char, bit eot);
    text_item_t it;
    it.ch       = ch;
    it.has_char = has_char;
    it.eot      = eot;
    it.pause    = pause_next;
    pause_next  = 1'b0;
    text_items.push_back(it);
    if (has_char || eot) begin
      stim_count++;
    end
  endfunction

  function automatic void add_str(string s, bit fold);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (fold && c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
        c = c ^ tts_pkg::CASE_BIT;
      end
      add_item(c, 1'b1, 1'b0);
    end
  endfunction

  function automatic void add_blanks(int unsigned n);
    repeat (n) add_item(BLANKS[$urandom_range(0, 3)], 1'b1, 1'b0);
  endfunction

  function automatic void end_text(bit on_last);
    text_item_t it;
    if (on_last && text_items.size() != 0 && text_items[$].has_char &&
        !text_items[$].eot) begin
      it = text_items.pop_back();
      it.eot = 1'b1;
      text_items.push_back(it);
    end else begin
      add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endfunction

  function automatic void add_fragment(frag_e kind);
    string tag;
    int unsigned pos;
    logic [7:0] c;
    case (kind)
      FRAG_BYTES: begin
        repeat ($urandom_range(1, 5)) add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      FRAG_WORD: begin
        repeat ($urandom_range(1, 6)) begin
          c = 8'($urandom_range(8'h61, 8'h7A));
          if ($urandom_range(0, 1) == 1) begin
            c = c ^ tts_pkg::CASE_BIT;
          end
          add_item(c, 1'b1, 1'b0);
        end
      end
      FRAG_BLANKS: begin
        add_blanks(($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 4));
      end
      FRAG_OPEN:  add_str("<think>", 1'b1);
      FRAG_CLOSE: add_str("</think>", 1'b1);
      FRAG_SELF: begin
        case ($urandom_range(0, 2))
          0:       add_str("<think/>", 1'b1);
          1:       add_str("<think />", 1'b1);
          default: add_str("<think/ />", 1'b1);
        endcase
      end
      FRAG_PREFIX: begin
        tag = ($urandom_range(0, 1) == 1) ? "<think />" : "</think>";
        add_str(tag.substr(0, $urandom_range(0, 6)), 1'b1);
      end
      FRAG_BROKEN: begin
        tag = ($urandom_range(0, 1) == 1) ? "<think>" : "</think>";
        pos = $urandom_range(0, tag.len() - 1);
        for (int i = 0; i < tag.len(); i++) begin
          c = (i == pos) ? 8'($urandom_range(0, 255)) : tag[i];
          add_item(c, 1'b1, 1'b0);
        end
      end
      default: add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endcase
  endfunction

  function automatic void build_directed();
    add_str(" A<THINK/>", 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(tts_pkg::CH_TAB, 1'b1, 1'b0);
    add_item(tts_pkg::CH_LF, 1'b1, 1'b1);
    add_item(8'h5A, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_str("<think />", 1'b0);
    add_item(8'hA5, 1'b0, 1'b1);
    add_str("<t<thInk>x", 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
  endfunction

  function automatic void build_random();
    frag_e kind;
    // hold store overflow, sender waits for the block to drain first
    pause_next = 1'b1;
    add_str("x", 1'b0);
    add_blanks($urandom_range(33, 40));
    add_str("y", 1'b0);
    end_text(1'b1);
    while (stim_count < STIM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        pause_next = 1'b1;
      end
      repeat ($urandom_range(1, 8)) begin
        kind = frag_e'($urandom_range(FRAG_BYTES, FRAG_NOOP));
        add_fragment(kind);
      end
      end_text($urandom_range(0, 1));
    end
  endfunction

  // driver
  text_item_t  cur_item;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      text_ch.valid       <= 1'b0;
      text_ch.text_byte   <= '0;
      text_ch.byte_valid  <= 1'b0;
      text_ch.end_of_text <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        predict_item(cur_item);
      end
      if (!text_ch.valid || text_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          text_ch.valid <= 1'b0;
        end else if (text_items.size() != 0 &&
                     !(text_items[0].pause && expected_q.size() != 0)) begin
          cur_item = text_items.pop_front();
          text_ch.valid       <= 1'b1;
          text_ch.text_byte   <= cur_item.ch;
          text_ch.byte_valid  <= cur_item.has_char;
          text_ch.end_of_text <= cur_item.eot;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  int unsigned rx_cycle;
  int unsigned stall_left;
  rx_mode_e    rx_mode;

  always @(posedge clk or negedge rst_n) begin
    strip_result_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      rx_cycle   = 0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected item: byte %02h valid %0d last %0d length %0d ovf %0d",
                     res_ch.out_byte, res_ch.out_valid, res_ch.run_last,
                     res_ch.kept_length, res_ch.hold_overflow);
          end
        end else begin
          want = expected_q.pop_front();
          if (res_ch.out_byte !== want.ch || res_ch.out_valid !== want.is_char ||
              res_ch.run_last !== want.last || res_ch.kept_length !== want.kept ||
              res_ch.hold_overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: exp byte %02h valid %0d last %0d length %0d ovf %0d",
                       $realtime, want.ch, want.is_char, want.last, want.kept, want.ovf);
              $display("                 got byte %02h valid %0d last %0d length %0d ovf %0d",
                       res_ch.out_byte, res_ch.out_valid, res_ch.run_last,
                       res_ch.kept_length, res_ch.hold_overflow);
            end
          end
        end
      end
      rx_mode = rx_mode_e'((rx_cycle / 300) % 3);
      rx_cycle++;
      case (rx_mode)
        RX_STEADY: res_ch.ready <= 1'b1;
        RX_JITTER: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15);
            res_ch.ready <= 1'b0;
          end else begin
            res_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin
    rst_n               = 1'b0;
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = '0;
    text_ch.byte_valid  = 1'b0;
    text_ch.end_of_text = 1'b0;
    res_ch.ready        = 1'b0;
    mismatches          = 0;
    stim_count          = 0;
    pause_next          = 1'b0;
    clear_stripper();
    build_directed();
    build_random();
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    while (text_items.size() != 0 || text_ch.valid || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d items pending, %0d results outstanding",
             text_items.size(), expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
